FILE: rtl/detuned_saw_oscillator_bank_top_macros.svh
// ----------------------------------------------------------------------------
// Supersaw oscillator bank assertion macros
// Shared concurrent assertion wrappers, sampled on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef DETUNED_SAW_OSCILLATOR_BANK_TOP_MACROS_SVH
`define DETUNED_SAW_OSCILLATOR_BANK_TOP_MACROS_SVH

// consequent checked in the same cycle
`define DSOB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define DSOB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/dsob_pkg.sv
// ----------------------------------------------------------------------------
// Supersaw oscillator bank package
// Shared constants, coefficient tables, codes and the seed LFSR step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dsob_pkg;

  localparam int VOICES         = 7;
  localparam int PHASE_BITS_DEF = 24;
  localparam int ADDR_W         = $clog2(VOICES);
  localparam int CNT_W          = $clog2(2 * VOICES);

  localparam int CMD_W    = 2;
  localparam int STEP_W   = 24;
  localparam int VOL_W    = 8;
  localparam int SEED_W   = 16;
  localparam int POT_W    = 24;
  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 17;

  localparam logic [POT_W-1:0]  POT_MAX     = 24'hFFFFFF;
  localparam logic [POT_W-1:0]  DECAY_LIMIT = 24'd21;
  localparam logic [16:0]       LEAK_MUL    = 17'd107374;
  localparam logic [31:0]       DECAY_MUL   = 32'd4294537800;
  localparam logic [SEED_W-1:0] LFSR_TAPS   = 16'hB400;
  localparam logic [SEED_W-1:0] ZERO_SEED   = 16'hACE1;

  // detune ratios, Q1.16
  localparam logic [COEF_W-1:0] DETUNE [VOICES] = '{
    17'd63767, 17'd64618, 17'd65339, 17'd65536, 17'd65798, 17'd66650, 17'd67240
  };

  // voice gains, Q1.15 (center voice is exactly 1.0)
  localparam logic signed [COEF_W-1:0] GAIN [VOICES] = '{
    17'sd8520, 17'sd15729, 17'sd24904, 17'sd32768, 17'sd24248, 17'sd17039, 17'sd7864
  };

  // right channel phase offset j*0.37 cycle, Q0.32, wrapped
  localparam logic [31:0] RIGHT_OFS [VOICES] = '{
    32'd0, 32'd1589137900, 32'd3178275800, 32'd472446404,
    32'd2061584304, 32'd3650722204, 32'd944892808
  };

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 2'd0,
    CMD_NOTE_ON  = 2'd1,
    CMD_NOTE_OFF = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_TICK,
    ST_FINAL,
    ST_EMIT
  } state_e;

  // eight Galois LFSR steps; two calls make one start phase
  function automatic logic [SEED_W-1:0] lfsr_adv8(input logic [SEED_W-1:0] s);
    logic [SEED_W-1:0] v;
    v = s;
    for (int k = 0; k < 8; k++) begin
      if (v[0]) begin
        v = (v >> 1) ^ LFSR_TAPS;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

endpackage

FILE: rtl/dsob_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dsob_ram #(
  parameter int WIDTH = dsob_pkg::PHASE_BITS_DEF,
  parameter int DEPTH = dsob_pkg::VOICES,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/detuned_saw_oscillator_bank_top.sv
// ----------------------------------------------------------------------------
// Supersaw oscillator bank, top level
// Seven detuned saw voices summed to a stereo sample with a decaying envelope.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command per transfer:
//   tick, note on (phase_step_i, volume_i, phase_seed_i) or note off.
//   Output channel (out_valid_o / out_stall_i) carries one stereo sample and
//   the decayed flag for every tick; note on/off produce no output.
//   Work per command, from its input transfer until the next one is taken:
//     tick     : the sample is registered in the output register at the end.
//     note on  : two 8-step LFSR passes per voice, one phase written to
//                the phase memory after every second pass.
//     note off : taken in the idle state; no further work follows.
//   A tick runs through the voice loop: the 7-entry phase memory is read
//   and written back once per voice, one voice per cycle, then a product and
//   a saturation stage.
//   A finished sample waits in the output register while out_stall_i is high;
//   note on/off and a further tick are still taken, but that tick holds in its
//   last stage, with in_stall_o high, until the register frees up.
//   Reset clears all phases (through per-entry valid bits), the envelope and
//   the step, and marks the note as stopped and decayed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "detuned_saw_oscillator_bank_top_macros.svh"

module detuned_saw_oscillator_bank_top #(
  parameter int PHASE_BITS = dsob_pkg::PHASE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [dsob_pkg::CMD_W-1:0]           command_i,
  input  logic [dsob_pkg::STEP_W-1:0]          phase_step_i,
  input  logic [dsob_pkg::VOL_W-1:0]           volume_i,
  input  logic [dsob_pkg::SEED_W-1:0]          phase_seed_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [dsob_pkg::SAMPLE_W-1:0] left_sample_o,
  output logic signed [dsob_pkg::SAMPLE_W-1:0] right_sample_o,
  output logic                                 decayed_o
);

  localparam int PB     = PHASE_BITS;
  localparam int VOICES = dsob_pkg::VOICES;
  localparam int AW     = dsob_pkg::ADDR_W;
  localparam int CW     = dsob_pkg::CNT_W;
  localparam int POT_W  = dsob_pkg::POT_W;
  localparam int SMP_W  = dsob_pkg::SAMPLE_W;
  localparam int CO_W   = dsob_pkg::COEF_W;
  localparam int SAW_W  = PB + 2;
  localparam int PROD_W = SAW_W + CO_W;
  localparam int ACC_W  = PB + 20;
  localparam int SHR    = PB - 8;
  localparam int SH_W   = ACC_W - SHR;
  localparam int MUL_W  = SH_W + POT_W + 1;
  localparam int R_W    = MUL_W - 26;
  localparam int STP_W  = PB + CO_W;

  localparam logic signed [SAW_W-1:0] FULL = SAW_W'(1) << PB;

  // control state
  dsob_pkg::state_e state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [VOICES-1:0] valid_q, valid_d;
  logic              stopped_q, stopped_d;
  logic              decayed_q, decayed_d;
  logic              rd_vld_q, rd_vld_d;
  logic              pr_vld_q, pr_vld_d;
  logic              out_valid_q, out_valid_d;
  logic [PB-1:0]     base_step_q, base_step_d;
  logic [POT_W-1:0]  pot_q, pot_d;
  logic [dsob_pkg::VOL_W-1:0] exc_q, exc_d;

  // datapath
  logic [dsob_pkg::SEED_W-1:0] lfsr_q, lfsr_d;
  logic [PB-1:0]               step_q, step_d;
  logic [AW-1:0]               rd_idx_q, rd_idx_d;
  logic [POT_W-1:0]            pot_sum_q, pot_sum_d;
  logic signed [PROD_W-1:0]    prod_l_q, prod_l_d, prod_r_q, prod_r_d;
  logic signed [ACC_W-1:0]     acc_l_q, acc_l_d, acc_r_q, acc_r_d;
  logic signed [MUL_W-1:0]     mul_l_q, mul_l_d, mul_r_q, mul_r_d;
  logic [SMP_W-1:0]            left_q, left_d, right_q, right_d;
  logic                        out_dec_q, out_dec_d;

  // phase memory port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [PB-1:0] ram_wdata, ram_rdata;

  logic in_acc, out_free;

  // combinational helpers
  logic [AW-1:0]            cnt_idx, rev_idx;
  logic [PB-1:0]            rd_pos, r_pos;
  logic [31:0]              rofs;
  logic signed [SAW_W-1:0]  saw_l, saw_r;
  logic [STP_W-1:0]         step_prod, step_rnd;
  logic [24:0]              leak_prod, leak_rnd, pot_add;
  logic [POT_W-1:0]         pot_sat;
  logic [55:0]              decay_prod;
  logic signed [SH_W-1:0]   s_l, s_r;
  logic signed [POT_W:0]    pot_s;
  logic signed [R_W-1:0]    r_l, r_r;

  function automatic logic [SMP_W-1:0] sat(input logic signed [R_W-1:0] v);
    logic [R_W-SMP_W:0] hi;
    logic [SMP_W-1:0]   res;
    hi = v[R_W-1:SMP_W-1];
    if ((&hi) || !(|hi)) begin
      res = v[SMP_W-1:0];
    end else if (v[R_W-1]) begin
      res = {1'b1, {(SMP_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(SMP_W-1){1'b1}}};
    end
    return res;
  endfunction

  dsob_ram #(
    .WIDTH (PB),
    .DEPTH (VOICES)
  ) u_phase_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o = (state_q != dsob_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // issue side: step of the voice being read
  assign cnt_idx   = cnt_q[AW-1:0];
  assign step_prod = STP_W'(base_step_q) * STP_W'(dsob_pkg::DETUNE[cnt_idx]);
  assign step_rnd  = step_prod + STP_W'(32768);

  // read-data side: never-written entries read as zero
  assign rd_pos  = valid_q[rd_idx_q] ? ram_rdata : '0;
  assign rofs    = dsob_pkg::RIGHT_OFS[rd_idx_q];
  assign r_pos   = rd_pos + rofs[31 -: PB];
  assign rev_idx = AW'(VOICES - 1) - rd_idx_q;
  assign saw_l   = $signed({1'b0, rd_pos, 1'b0}) - FULL;
  assign saw_r   = $signed({1'b0, r_pos, 1'b0}) - FULL;

  // envelope: leak, saturate, then decay
  assign leak_prod  = 25'(exc_q) * 25'(dsob_pkg::LEAK_MUL);
  assign leak_rnd   = leak_prod + 25'd32768;
  assign pot_add    = {1'b0, pot_q} + 25'(leak_rnd[24:16]);
  assign pot_sat    = pot_add[24] ? dsob_pkg::POT_MAX : pot_add[POT_W-1:0];
  assign decay_prod = 56'(pot_sum_q) * 56'(dsob_pkg::DECAY_MUL);

  // output scaling
  assign s_l   = SH_W'(acc_l_q >>> SHR);
  assign s_r   = SH_W'(acc_r_q >>> SHR);
  assign pot_s = $signed({1'b0, pot_q});
  assign r_l   = R_W'(mul_l_q >>> 26);
  assign r_r   = R_W'(mul_r_q >>> 26);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    valid_d     = valid_q;
    stopped_d   = stopped_q;
    decayed_d   = decayed_q;
    rd_vld_d    = 1'b0;
    pr_vld_d    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    base_step_d = base_step_q;
    pot_d       = pot_q;
    exc_d       = exc_q;
    lfsr_d      = lfsr_q;
    step_d      = step_q;
    rd_idx_d    = rd_idx_q;
    pot_sum_d   = pot_sum_q;
    prod_l_d    = prod_l_q;
    prod_r_d    = prod_r_q;
    acc_l_d     = acc_l_q;
    acc_r_d     = acc_r_q;
    mul_l_d     = mul_l_q;
    mul_r_d     = mul_r_q;
    left_d      = left_q;
    right_d     = right_q;
    out_dec_d   = out_dec_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = '0;
    ram_raddr   = '0;
    ram_wdata   = '0;

    unique case (state_q)
      dsob_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (dsob_pkg::cmd_e'(command_i))
            dsob_pkg::CMD_NOTE_ON: begin
              lfsr_d      = (phase_seed_i == '0) ? dsob_pkg::ZERO_SEED : phase_seed_i;
              base_step_d = PB'(phase_step_i);
              exc_d       = volume_i;
              pot_d       = POT_W'(volume_i) << 15;
              stopped_d   = 1'b0;
              decayed_d   = 1'b0;
              cnt_d       = '0;
              state_d     = dsob_pkg::ST_SEED;
            end
            dsob_pkg::CMD_NOTE_OFF: begin
              exc_d     = '0;
              stopped_d = 1'b1;
            end
            dsob_pkg::CMD_TICK: begin
              acc_l_d = '0;
              acc_r_d = '0;
              cnt_d   = '0;
              state_d = dsob_pkg::ST_TICK;
            end
            default: ;
          endcase
        end
      end

      dsob_pkg::ST_SEED: begin
        lfsr_d = dsob_pkg::lfsr_adv8(lfsr_q);
        if (cnt_q[0]) begin
          ram_we             = 1'b1;
          ram_waddr          = cnt_q[AW:1];
          ram_wdata          = PB'(lfsr_d) << (PB - 16);
          valid_d[ram_waddr] = 1'b1;
        end
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(2 * VOICES - 1)) begin
          state_d = dsob_pkg::ST_IDLE;
        end
      end

      dsob_pkg::ST_TICK: begin
        cnt_d = cnt_q + CW'(1);
        // stage A: read voice, compute its detuned step
        if (cnt_q < CW'(VOICES)) begin
          ram_re    = 1'b1;
          ram_raddr = cnt_idx;
          rd_idx_d  = cnt_idx;
          rd_vld_d  = 1'b1;
          step_d    = step_rnd[PB+15:16];
        end
        // stage B: write back advanced phase, weight both saws
        if (rd_vld_q) begin
          ram_we             = 1'b1;
          ram_waddr          = rd_idx_q;
          ram_wdata          = rd_pos + step_q;
          valid_d[rd_idx_q]  = 1'b1;
          prod_l_d           = saw_l * dsob_pkg::GAIN[rd_idx_q];
          prod_r_d           = saw_r * dsob_pkg::GAIN[rev_idx];
          pr_vld_d           = 1'b1;
        end
        // stage C: accumulate
        if (pr_vld_q) begin
          acc_l_d = acc_l_q + ACC_W'(prod_l_q);
          acc_r_d = acc_r_q + ACC_W'(prod_r_q);
        end
        if (cnt_q == CW'(0)) begin
          pot_sum_d = pot_sat;
        end
        if (cnt_q == CW'(1)) begin
          pot_d = decay_prod[55:32];
        end
        if (cnt_q == CW'(VOICES + 1)) begin
          state_d = dsob_pkg::ST_FINAL;
        end
      end

      dsob_pkg::ST_FINAL: begin
        mul_l_d = s_l * pot_s;
        mul_r_d = s_r * pot_s;
        if (stopped_q && (pot_q < dsob_pkg::DECAY_LIMIT)) begin
          decayed_d = 1'b1;
        end
        state_d = dsob_pkg::ST_EMIT;
      end

      dsob_pkg::ST_EMIT: begin
        if (out_free) begin
          left_d      = sat(r_l);
          right_d     = sat(r_r);
          out_dec_d   = decayed_q;
          out_valid_d = 1'b1;
          state_d     = dsob_pkg::ST_IDLE;
        end
      end

      default: state_d = dsob_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dsob_pkg::ST_IDLE;
      cnt_q       <= '0;
      valid_q     <= '0;
      stopped_q   <= 1'b1;
      decayed_q   <= 1'b1;
      rd_vld_q    <= 1'b0;
      pr_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      base_step_q <= '0;
      pot_q       <= '0;
      exc_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      valid_q     <= valid_d;
      stopped_q   <= stopped_d;
      decayed_q   <= decayed_d;
      rd_vld_q    <= rd_vld_d;
      pr_vld_q    <= pr_vld_d;
      out_valid_q <= out_valid_d;
      base_step_q <= base_step_d;
      pot_q       <= pot_d;
      exc_q       <= exc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lfsr_q    <= lfsr_d;
    step_q    <= step_d;
    rd_idx_q  <= rd_idx_d;
    pot_sum_q <= pot_sum_d;
    prod_l_q  <= prod_l_d;
    prod_r_q  <= prod_r_d;
    acc_l_q   <= acc_l_d;
    acc_r_q   <= acc_r_d;
    mul_l_q   <= mul_l_d;
    mul_r_q   <= mul_r_d;
    left_q    <= left_d;
    right_q   <= right_d;
    out_dec_q <= out_dec_d;
  end

  assign out_valid_o    = out_valid_q;
  assign left_sample_o  = left_q;
  assign right_sample_o = right_q;
  assign decayed_o      = out_dec_q;

  // read and write-back of the same voice never share a cycle
  `DSOB_ASSERT_SAME(a_no_rw_clash, ram_we && ram_re, ram_waddr != ram_raddr, "phase rd/wr clash")
  `DSOB_ASSERT_SAME(a_we_state, ram_we, (state_q == dsob_pkg::ST_SEED) || (state_q == dsob_pkg::ST_TICK), "phase write outside seed/tick")
  `DSOB_ASSERT_SAME(a_out_from_emit, $rose(out_valid_q), $past(state_q) == dsob_pkg::ST_EMIT, "sample appeared outside emit")
  `DSOB_ASSERT_NEXT(a_decay_sticky, decayed_q && !(in_acc && (command_i == dsob_pkg::CMD_NOTE_ON)), decayed_q, "decayed flag dropped without note on")
  `DSOB_ASSERT_SAME(a_playing_not_decayed, !stopped_q, !decayed_q, "decayed while note playing")

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// Supersaw oscillator bank testbench
// Drives tick, note on, note off and the unused command code through the
// input channel with random gaps. A built-in envelope and voice predictor
// computes each stereo sample, which is compared with the output channel
// while the sink stalls at random. Covers field extremes, the zero seed, the
// decayed flag on silent and stopped notes and random note sequences.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import dsob_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int IDLE_LIMIT   = 4000;
  localparam int REPORT_LIMIT = 10;

  // envelope and voice arithmetic
  localparam logic [63:0]       ENV_LEAK      = 64'd107374;
  localparam logic [63:0]       ENV_DECAY     = 64'd4294537800;
  localparam logic [63:0]       ENV_CEIL      = 64'hFFFFFF;
  localparam logic [POT_W-1:0]  ENV_FLOOR     = 24'd21;
  localparam logic [SEED_W-1:0] SEED_TAPS     = 16'hB400;
  localparam logic [SEED_W-1:0] SEED_FALLBACK = 16'hACE1;
  localparam logic [31:0]       RIGHT_STEP    = 32'd1589137900;
  localparam longint            FULL_SCALE    = 64'sd16777216;
  localparam int DETUNE_Q16 [VOICES] = '{63767, 64618, 65339, 65536, 65798, 66650, 67240};
  localparam int VOICE_GAIN [VOICES] = '{8520, 15729, 24904, 32768, 24248, 17039, 7864};

  typedef struct {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       decayed;
  } stereo_sample_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [CMD_W-1:0]           command_i;
  logic [STEP_W-1:0]          phase_step_i;
  logic [VOL_W-1:0]           volume_i;
  logic [SEED_W-1:0]          phase_seed_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic signed [SAMPLE_W-1:0] left_sample_o;
  logic signed [SAMPLE_W-1:0] right_sample_o;
  logic                       decayed_o;

  // predicted block state
  logic [23:0]       osc_phase [VOICES];
  logic [23:0]       osc_step;
  logic [POT_W-1:0]  env_pot;
  logic [VOL_W-1:0]  env_exc;
  logic              note_stopped;
  logic              note_decayed;

  stereo_sample_t pending_samples [$];
  int             fault_count   = 0;
  int             samples_seen  = 0;
  int             items_sent    = 0;
  int             idle_cycles   = 0;
  bit             no_idle       = 1'b0;

  detuned_saw_oscillator_bank_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .phase_step_i   (phase_step_i),
    .volume_i       (volume_i),
    .phase_seed_i   (phase_seed_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .left_sample_o  (left_sample_o),
    .right_sample_o (right_sample_o),
    .decayed_o      (decayed_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [SEED_W-1:0] lfsr_16_steps(input logic [SEED_W-1:0] s);
    logic [SEED_W-1:0] v;
    v = s;
    for (int k = 0; k < 16; k++) begin
      v = v[0] ? ((v >> 1) ^ SEED_TAPS) : (v >> 1);
    end
    return v;
  endfunction

  // floor-scale a voice sum by the envelope, Q3.20 with saturation
  function automatic logic signed [SAMPLE_W-1:0] to_sample(input longint sum,
                                                           input logic [POT_W-1:0] pot);
    longint scaled;
    longint prod;
    scaled = sum >>> 16;
    prod   = (scaled * longint'({40'd0, pot})) >>> 26;
    if (prod > 64'sd8388607) begin
      prod = 64'sd8388607;
    end else if (prod < -64'sd8388608) begin
      prod = -64'sd8388608;
    end
    return prod[SAMPLE_W-1:0];
  endfunction

  function automatic void apply_command(input logic [CMD_W-1:0]  cmd,
                                        input logic [STEP_W-1:0] step,
                                        input logic [VOL_W-1:0]  vol,
                                        input logic [SEED_W-1:0] seed);
    logic [SEED_W-1:0] lfsr;
    logic [63:0]       pot;
    logic [63:0]       inc;
    logic [31:0]       ofs;
    logic [23:0]       pos;
    logic [23:0]       shifted;
    longint            lsum;
    longint            rsum;
    stereo_sample_t    res;
    case (cmd)
      CMD_NOTE_ON: begin
        lfsr = (seed == '0) ? SEED_FALLBACK : seed;
        for (int j = 0; j < VOICES; j++) begin
          lfsr         = lfsr_16_steps(lfsr);
          osc_phase[j] = {lfsr, 8'h00};
        end
        osc_step     = step;
        env_exc      = vol;
        env_pot      = {1'b0, vol, 15'd0};
        note_stopped = 1'b0;
        note_decayed = 1'b0;
      end
      CMD_NOTE_OFF: begin
        env_exc      = '0;
        note_stopped = 1'b1;
      end
      CMD_TICK: begin
        pot = 64'(env_pot) + ((64'(env_exc) * ENV_LEAK + 64'd32768) >> 16);
        if (pot > ENV_CEIL) begin
          pot = ENV_CEIL;
        end
        pot     = (pot * ENV_DECAY) >> 32;
        env_pot = pot[POT_W-1:0];
        lsum    = 0;
        rsum    = 0;
        for (int j = 0; j < VOICES; j++) begin
          pos     = osc_phase[j];
          ofs     = 32'(j) * RIGHT_STEP;
          shifted = pos + ofs[31:8];
          inc     = (64'(osc_step) * 64'(DETUNE_Q16[j]) + 64'd32768) >> 16;
          lsum += (2 * longint'({40'd0, pos}) - FULL_SCALE) * VOICE_GAIN[j];
          rsum += (2 * longint'({40'd0, shifted}) - FULL_SCALE) * VOICE_GAIN[VOICES-1-j];
          osc_phase[j] = pos + inc[23:0];
        end
        if (note_stopped && env_pot < ENV_FLOOR) begin
          note_decayed = 1'b1;
        end
        res.left    = to_sample(lsum, env_pot);
        res.right   = to_sample(rsum, env_pot);
        res.decayed = note_decayed;
        pending_samples.push_back(res);
      end
      default: begin
      end
    endcase
  endfunction

  // ------------------------------------------------------------------ sender

  function automatic int sender_gap();
    if (no_idle) begin
      return 0;
    end
    return ($urandom_range(0, 11) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
  endfunction

  // zero, all ones, a small value or anything within the field
  function automatic logic [31:0] pick_value(input int unsigned bits);
    logic [31:0] all_ones;
    all_ones = (32'd1 << bits) - 32'd1;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return all_ones;
      2:       return $urandom_range(1, 255);
      default: return $urandom & all_ones;
    endcase
  endfunction

  task automatic send_item(input logic [CMD_W-1:0]  cmd,
                           input logic [STEP_W-1:0] step,
                           input logic [VOL_W-1:0]  vol,
                           input logic [SEED_W-1:0] seed);
    int gap;
    gap = sender_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    phase_step_i <= step;
    volume_i     <= vol;
    phase_seed_i <= seed;
    do @(posedge clk_i); while (in_stall_o);
    apply_command(cmd, step, vol, seed);
    if (cmd != CMD_UNUSED) begin
      items_sent++;
    end
  endtask

  // payload the block ignores carries junk
  task automatic send_junk(input logic [CMD_W-1:0] cmd);
    send_item(cmd, STEP_W'($urandom), VOL_W'($urandom), SEED_W'($urandom));
  endtask

  task automatic send_tick();
    send_junk(CMD_TICK);
  endtask

  task automatic drain_outputs();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
  endtask

  // ------------------------------------------------------------------ checker

  function automatic void report_fault(input string msg);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) begin
      $display("%s", msg);
    end
  endfunction

  function automatic void check_field(input string name, input integer want,
                                      input integer got);
    if (got !== want) begin
      report_fault($sformatf("sample %0d: %s expected %0d, got %0d",
                             samples_seen, name, want, got));
    end
  endfunction

  always @(posedge clk_i) begin : sample_check
    stereo_sample_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_samples.size() == 0) begin
        report_fault($sformatf("sample %0d: unexpected transfer L=%0d R=%0d D=%0b",
                               samples_seen, left_sample_o, right_sample_o, decayed_o));
      end else begin
        want = pending_samples.pop_front();
        check_field("left", want.left, left_sample_o);
        check_field("right", want.right, right_sample_o);
        check_field("decayed", want.decayed, decayed_o);
      end
      samples_seen++;
    end
  end

  // sink backpressure: mostly short stalls, a few long ones, some quiet runs
  initial begin : sink_pacing
    int n;
    out_stall_i = 1'b0;
    forever begin
      if (no_idle) begin
        n = 8;
      end else begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      end
      repeat (n) @(negedge clk_i);
      if (!no_idle) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 4);
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // -------------------------------------------------------------------- tests

  // stopped, silent and decayed straight out of reset
  task automatic test_after_reset();
    send_tick();
    send_tick();
    send_junk(CMD_UNUSED);
    send_tick();
  endtask

  task automatic test_field_extremes();
    send_item(CMD_NOTE_ON, 24'hFFFFFF, 8'hFF, 16'hFFFF);
    repeat (3) send_tick();
    // zero seed falls back to the fixed start state
    send_item(CMD_NOTE_ON, 24'h000000, 8'h00, 16'h0000);
    repeat (2) send_tick();
    send_item(CMD_NOTE_ON, 24'h800000, 8'h80, 16'h0001);
    send_tick();
    send_junk(CMD_NOTE_OFF);
    repeat (2) send_tick();
    send_item(CMD_NOTE_ON, 24'h000001, 8'h01, 16'h8000);
    send_tick();
    send_junk(CMD_NOTE_OFF);
    send_junk(CMD_NOTE_OFF);
    send_junk(CMD_UNUSED);
    send_tick();
  endtask

  task automatic test_decay_flag();
    // silent note: flag held low until stopped, then set on the next tick
    send_item(CMD_NOTE_ON, STEP_W'($urandom), 8'h00, SEED_W'($urandom));
    send_tick();
    send_junk(CMD_NOTE_OFF);
    repeat (2) send_tick();
    send_item(CMD_NOTE_ON, STEP_W'($urandom), 8'h01, SEED_W'($urandom));
    send_tick();
    // quietest audible note, stopped but still far above the threshold
    send_junk(CMD_NOTE_OFF);
    no_idle = 1'b1;
    repeat (12) send_tick();
    no_idle = 1'b0;
    send_junk(CMD_NOTE_ON);
    send_tick();
  endtask

  task automatic test_random_traffic();
    int stop_at;
    bit paused;
    stop_at = items_sent + 700;
    paused  = 1'b0;
    while (items_sent < stop_at) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 7) == 0) begin
        // stray commands of any code, unused one included
        repeat ($urandom_range(1, 4)) send_junk(CMD_W'($urandom));
      end else begin
        send_item(CMD_NOTE_ON, STEP_W'(pick_value(STEP_W)), VOL_W'(pick_value(VOL_W)),
                  SEED_W'(pick_value(SEED_W)));
        repeat ($urandom_range(2, 30)) send_tick();
        if ($urandom_range(0, 2) != 0) begin
          send_junk(CMD_NOTE_OFF);
          repeat ($urandom_range(1, 12)) send_tick();
        end
      end
      if (!paused && items_sent > stop_at - 350) begin
        drain_outputs();
        paused = 1'b1;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin : run_all
    in_valid_i   = 1'b0;
    command_i    = CMD_TICK;
    phase_step_i = '0;
    volume_i     = '0;
    phase_seed_i = '0;
    rst_ni       = 1'b0;
    for (int j = 0; j < VOICES; j++) begin
      osc_phase[j] = '0;
    end
    osc_step     = '0;
    env_pot      = '0;
    env_exc      = '0;
    note_stopped = 1'b1;
    note_decayed = 1'b1;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_after_reset();
    test_field_extremes();
    test_decay_flag();
    test_random_traffic();

    drain_outputs();
    repeat (40) @(posedge clk_i);
    if (pending_samples.size() != 0) begin
      report_fault($sformatf("%0d samples never arrived", pending_samples.size()));
    end
    if (fault_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/dsob_pkg.sv
rtl/dsob_ram.sv
rtl/detuned_saw_oscillator_bank_top.sv
sim/testbench.sv
